/* hdl/spicr_pkg.sv */
// ----------------------------------------------------------------------------
// spicr_pkg: shared types and constants of the SPI controller register unit
// Register offsets, FIFO sizing, ID words and the controller command word.
// ----------------------------------------------------------------------------
package spicr_pkg;

  // Receive FIFO sizing
  localparam int FIFO_DEPTH = 8;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int FILL_W     = $clog2(FIFO_DEPTH + 1);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(FIFO_DEPTH);
  localparam logic [FILL_W-1:0] FILL_HALF = FILL_W'(FIFO_DEPTH / 2);
  localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(FIFO_DEPTH - 1);

  // Field widths
  localparam int OFS_W  = 12;
  localparam int WDAT_W = 32;
  localparam int HALF_W = 16;

  // Request types
  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  // Register offsets
  localparam logic [OFS_W-1:0] OFS_CR0   = 12'h000;
  localparam logic [OFS_W-1:0] OFS_CR1   = 12'h004;
  localparam logic [OFS_W-1:0] OFS_DR    = 12'h008;
  localparam logic [OFS_W-1:0] OFS_SR    = 12'h00C;
  localparam logic [OFS_W-1:0] OFS_CPSR  = 12'h010;
  localparam logic [OFS_W-1:0] OFS_IMSC  = 12'h014;
  localparam logic [OFS_W-1:0] OFS_RIS   = 12'h018;
  localparam logic [OFS_W-1:0] OFS_MIS   = 12'h01C;
  localparam logic [OFS_W-1:0] OFS_ICR   = 12'h020;
  localparam logic [OFS_W-1:0] OFS_DMACR = 12'h024;
  localparam logic [OFS_W-1:0] OFS_ID0   = 12'hFE0;
  localparam logic [OFS_W-1:0] OFS_ID1   = 12'hFE4;
  localparam logic [OFS_W-1:0] OFS_ID2   = 12'hFE8;
  localparam logic [OFS_W-1:0] OFS_ID3   = 12'hFEC;

  // ID words
  localparam logic [HALF_W-1:0] ID0_VAL = 16'h0022;
  localparam logic [HALF_W-1:0] ID1_VAL = 16'h0010;
  localparam logic [HALF_W-1:0] ID2_VAL = 16'h0004;
  localparam logic [HALF_W-1:0] ID3_VAL = 16'h0000;

  // Raw interrupt bit positions
  localparam int RIS_ROR = 0;
  localparam int RIS_RT  = 1;
  localparam int RIS_RX  = 2;
  localparam int RIS_TX  = 3;

  // Port control enable bit
  localparam int CR1_SSE = 1;

  // Controller to datapath command word
  typedef struct packed {
    logic load;  // capture the request word
    logic exec;  // apply the access to the register state
    logic resp;  // present the result word
  } cmd_t;

endpackage

/* hdl/spicr_ram.sv */
// ----------------------------------------------------------------------------
// spicr_ram: generic single write, single read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module spicr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hdl/spicr_ctrl.sv */
// ----------------------------------------------------------------------------
// spicr_ctrl: access sequencer
// Steps each accepted word through capture, execute and respond.
// ----------------------------------------------------------------------------
module spicr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  output spicr_pkg::cmd_t     cmd
);
  import spicr_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_RESP = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_EXEC;
      end
      ST_EXEC: state_nxt = ST_RESP;
      ST_RESP: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy     = (state_r != ST_IDLE);
  assign cmd.load = (state_r == ST_IDLE) && start;
  assign cmd.exec = (state_r == ST_EXEC);
  assign cmd.resp = (state_r == ST_RESP);

endmodule

/* hdl/spicr_dp.sv */
// ----------------------------------------------------------------------------
// spicr_dp: register file, receive FIFO and result datapath
// Holds the control registers and FIFO pointers, applies one access per
// execute command and registers the result word.
// ----------------------------------------------------------------------------
module spicr_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  spicr_pkg::cmd_t                 cmd,
  input  logic                            in_req_type,
  input  logic [spicr_pkg::OFS_W-1:0]     in_reg_offset,
  input  logic [spicr_pkg::WDAT_W-1:0]    in_write_data,
  input  logic                            in_device_present,
  input  logic [spicr_pkg::HALF_W-1:0]    in_device_miso,
  output logic [spicr_pkg::HALF_W-1:0]    out_read_data,
  output logic                            out_irq,
  output logic                            out_mosi_valid,
  output logic                            out_mosi_wide,
  output logic [spicr_pkg::HALF_W-1:0]    out_mosi_frame
);
  import spicr_pkg::*;

  // Captured request
  logic                 req_r;
  logic [OFS_W-1:0]     ofs_r;
  logic [WDAT_W-1:0]    wdat_r;
  logic                 present_r;
  logic [HALF_W-1:0]    miso_r;

  // Architectural state
  logic [PTR_W-1:0]     head_r, head_nxt;
  logic [PTR_W-1:0]     tail_r, tail_nxt;
  logic [FILL_W-1:0]    fill_r, fill_nxt;
  logic [HALF_W-1:0]    cr0_r, cr0_nxt;
  logic [3:0]           cr1_r, cr1_nxt;
  logic [7:0]           cpsr_r, cpsr_nxt;
  logic [3:0]           imsc_r, imsc_nxt;
  logic [3:0]           ris_r, ris_nxt;
  logic [1:0]           dmacr_r, dmacr_nxt;

  // Result word
  logic [HALF_W-1:0]    rd_r, rd_nxt;
  logic                 fifo_rd_r;
  logic                 irq_r;
  logic                 sent_r;
  logic                 wide_r;
  logic [HALF_W-1:0]    frame_r, frame_nxt;

  logic                 is_wr;
  logic                 wide;
  logic                 send;
  logic                 full;
  logic                 push;
  logic                 pop;
  logic [HALF_W-1:0]    answer;
  logic [HALF_W-1:0]    ram_q;

  assign is_wr  = (req_r == REQ_WRITE);
  assign wide   = cr0_r[3];
  assign full   = (fill_r == FILL_FULL);
  assign send   = is_wr && (ofs_r == OFS_DR) && cr1_r[CR1_SSE];
  assign push   = send && !full;
  assign pop    = !is_wr && (ofs_r == OFS_DR) && (fill_r != '0);
  assign answer = !present_r ? '0 :
                  (wide ? miso_r : {8'h00, miso_r[7:0]});

  always_comb begin
    frame_nxt = wide ? wdat_r[HALF_W-1:0] : {8'h00, wdat_r[7:0]};
  end

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    fill_nxt  = fill_r;
    cr0_nxt   = cr0_r;
    cr1_nxt   = cr1_r;
    cpsr_nxt  = cpsr_r;
    imsc_nxt  = imsc_r;
    ris_nxt   = ris_r;
    dmacr_nxt = dmacr_r;

    if (push) begin
      head_nxt = (head_r == PTR_LAST) ? '0 : head_r + PTR_W'(1);
      fill_nxt = fill_r + FILL_W'(1);
    end
    if (pop) begin
      tail_nxt = (tail_r == PTR_LAST) ? '0 : tail_r + PTR_W'(1);
      fill_nxt = fill_r - FILL_W'(1);
    end

    if (is_wr) begin
      unique case (ofs_r)
        OFS_CR0:   cr0_nxt   = wdat_r[HALF_W-1:0];
        OFS_CR1:   cr1_nxt   = wdat_r[3:0];
        OFS_CPSR:  cpsr_nxt  = wdat_r[7:0];
        OFS_IMSC:  imsc_nxt  = wdat_r[3:0];
        OFS_ICR:   ris_nxt   = ris_r & ~{2'b00, wdat_r[1:0]};
        OFS_DMACR: dmacr_nxt = wdat_r[1:0];
        default:   ;
      endcase
    end

    // drop the answer and flag overrun when the FIFO is full
    if (send && full) ris_nxt[RIS_ROR] = 1'b1;

    // refresh level flags after any write and after a data read
    if (is_wr || (ofs_r == OFS_DR)) begin
      ris_nxt[RIS_TX] = 1'b1;
      ris_nxt[RIS_RX] = (fill_nxt >= FILL_HALF);
    end
  end

  always_comb begin
    rd_nxt = '0;
    if (!is_wr) begin
      unique case (ofs_r)
        OFS_CR0:   rd_nxt = cr0_r;
        OFS_CR1:   rd_nxt = {12'h000, cr1_r};
        OFS_SR:    rd_nxt = {12'h000, full, (fill_r != '0), 2'b11};
        OFS_CPSR:  rd_nxt = {8'h00, cpsr_r};
        OFS_IMSC:  rd_nxt = {12'h000, imsc_r};
        OFS_RIS:   rd_nxt = {12'h000, ris_r};
        OFS_MIS:   rd_nxt = {12'h000, ris_r & imsc_r};
        OFS_DMACR: rd_nxt = {14'h0000, dmacr_r};
        OFS_ID0:   rd_nxt = ID0_VAL;
        OFS_ID1:   rd_nxt = ID1_VAL;
        OFS_ID2:   rd_nxt = ID2_VAL;
        OFS_ID3:   rd_nxt = ID3_VAL;
        default:   rd_nxt = '0;
      endcase
    end
  end

  spicr_ram #(
    .WIDTH (HALF_W),
    .DEPTH (FIFO_DEPTH)
  ) u_rx_ram (
    .clk   (clk),
    .we    (cmd.exec && push),
    .waddr (head_r),
    .wdata (answer),
    .re    (cmd.exec && pop),
    .raddr (tail_r),
    .rdata (ram_q)
  );

  // capture the request word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r     <= in_req_type;
      ofs_r     <= in_reg_offset;
      wdat_r    <= in_write_data;
      present_r <= in_device_present;
      miso_r    <= in_device_miso;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      fill_r  <= '0;
      cr0_r   <= '0;
      cr1_r   <= '0;
      cpsr_r  <= '0;
      imsc_r  <= '0;
      ris_r   <= '0;
      dmacr_r <= '0;
    end else if (cmd.exec) begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      fill_r  <= fill_nxt;
      cr0_r   <= cr0_nxt;
      cr1_r   <= cr1_nxt;
      cpsr_r  <= cpsr_nxt;
      imsc_r  <= imsc_nxt;
      ris_r   <= ris_nxt;
      dmacr_r <= dmacr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rd_r      <= rd_nxt;
      fifo_rd_r <= pop;
      irq_r     <= |(ris_nxt & imsc_nxt);
      sent_r    <= send;
      wide_r    <= send && wide;
      frame_r   <= send ? frame_nxt : '0;
    end
  end

  assign out_read_data  = fifo_rd_r ? ram_q : rd_r;
  assign out_irq        = irq_r;
  assign out_mosi_valid = sent_r;
  assign out_mosi_wide  = wide_r;
  assign out_mosi_frame = frame_r;

endmodule

/* hdl/spi_controller_registers_unit.sv */
// ----------------------------------------------------------------------------
// spi_controller_registers_unit: SPI controller register model
// Executes one register read or write per command and reports the result.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive in_* and raise start; the word is taken at the
//   rising edge where start is high and busy is low. busy stays high while
//   the word is worked on.
//   Result channel: out_strobe is high for exactly one cycle and carries
//   out_read_data, out_irq and the out_mosi_* frame report of that word.
//   The receiver cannot stall, so the result is shown once and dropped.
//   The result strobe comes in the respond step, after the execute step.
//   A new word is taken only after the capture, execute and respond steps
//   of the sequencer are through; the execute step needs the registered
//   read of the receive FIFO RAM before the data can be shown.
//   A data write while the port is enabled sends a frame at once and pushes
//   the device answer into the receive FIFO; a full FIFO flags overrun.
//   A data read pops the FIFO, reading zero when it is empty.
//   Reset (rst_n low, synchronous) clears all control registers, the FIFO
//   pointers and the fill count; FIFO contents are not cleared and are never
//   read before being written.
// ----------------------------------------------------------------------------
module spi_controller_registers_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic                            in_req_type,
  input  logic [spicr_pkg::OFS_W-1:0]     in_reg_offset,
  input  logic [spicr_pkg::WDAT_W-1:0]    in_write_data,
  input  logic                            in_device_present,
  input  logic [spicr_pkg::HALF_W-1:0]    in_device_miso,
  output logic                            out_strobe,
  output logic [spicr_pkg::HALF_W-1:0]    out_read_data,
  output logic                            out_irq,
  output logic                            out_mosi_valid,
  output logic                            out_mosi_wide,
  output logic [spicr_pkg::HALF_W-1:0]    out_mosi_frame
);
  import spicr_pkg::*;

  cmd_t cmd;

  // sequencer: capture, execute, respond
  spicr_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  // registers, receive FIFO and result word
  spicr_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_req_type       (in_req_type),
    .in_reg_offset     (in_reg_offset),
    .in_write_data     (in_write_data),
    .in_device_present (in_device_present),
    .in_device_miso    (in_device_miso),
    .out_read_data     (out_read_data),
    .out_irq           (out_irq),
    .out_mosi_valid    (out_mosi_valid),
    .out_mosi_wide     (out_mosi_wide),
    .out_mosi_frame    (out_mosi_frame)
  );

  // hold the strobe for the single respond cycle
  assign out_strobe = cmd.resp;

endmodule
